// File: hdl/qpn_pkg.sv
// qpn_pkg: shared constants for the normalized quaternion product block.
// No dependencies; used by every module under hdl but qpn_queue.
package qpn_pkg;

    // default component format, signed Q2.14
    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int FRACTION_BITS_DEF   = 14;

    // component magnitudes are cut to below 2^A_BITS before squaring
    localparam int A_BITS = 31;
    localparam int ASQ_W  = 2 * A_BITS;
    // sum of four squares
    localparam int SUM_W  = ASQ_W + 2;

    // queue entry: four squares, S, four signs, zero flag
    localparam int QENTRY_W   = 4 * ASQ_W + SUM_W + 4 + 1;
    localparam int QUEUE_DEPTH = 4;

endpackage

// File: hdl/quaternion_product_normalized.sv
// quaternion_product_normalized: top level, front part, queue and back part.
// Depends on qpn_pkg, qpn_front, qpn_queue and qpn_back.
//
// channel   direction  payload (lowest bit up)
// s_axis    in         tdata: lhs_x, lhs_y, lhs_z, lhs_w, rhs_x, rhs_y, rhs_z, rhs_w
// m_axis    out        tdata: out_x, out_y, out_z, out_w (zero pad); tuser: zero_norm
//
// One item per cycle sustained while m_axis accepts. An item passes the front stages,
// the queue and the back stages; the back length is set by the root recurrence,
// which resolves one result bit per stage.
// Reset is synchronous, active low, and clears valid bits and queue pointers.
// A stalled output holds the back part; the queue then fills and holds the front.
module quaternion_product_normalized #(
    parameter int COMPONENT_WIDTH = qpn_pkg::COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = qpn_pkg::FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // lhs_x, lhs_y, lhs_z, lhs_w, rhs_x, rhs_y, rhs_z, rhs_w
    input  logic [8*COMPONENT_WIDTH-1:0] i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // out_x, out_y, out_z, out_w, zero pad to whole bytes
    output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // zero_norm
    output logic [0:0]               o_m_axis_tuser
);
    localparam int ODW = ((4 * COMPONENT_WIDTH + 7) / 8) * 8;

    logic                         f_valid;
    logic                         q_full;
    logic [qpn_pkg::QENTRY_W-1:0] f_entry;
    logic                         q_valid;
    logic                         b_pop;
    logic [qpn_pkg::QENTRY_W-1:0] q_entry;
    logic [4*COMPONENT_WIDTH-1:0] b_data;
    logic                         b_zero;

    qpn_front #(
        .CW(COMPONENT_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_valid (f_valid),
        .i_ready (!q_full),
        .o_entry (f_entry)
    );

    qpn_queue #(
        .WIDTH(qpn_pkg::QENTRY_W),
        .DEPTH(qpn_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_entry),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_data  (q_entry)
    );

    qpn_back #(
        .CW(COMPONENT_WIDTH),
        .FB(FRACTION_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (b_pop),
        .i_entry (q_entry),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (b_data),
        .o_zero  (b_zero)
    );

    assign o_m_axis_tdata = ODW'(b_data);
    assign o_m_axis_tuser = b_zero;

endmodule

// File: hdl/qpn_queue.sv
// qpn_queue: small register FIFO between the front and back parts.
// Depends on nothing but its parameters; DEPTH must be a power of two.
module qpn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CNW-1:0]   r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + PW'(1);
            if (w_pop) r_rd <= r_rd + PW'(1);
            if (w_push && !w_pop) r_cnt <= r_cnt + CNW'(1);
            else if (w_pop && !w_push) r_cnt <= r_cnt - CNW'(1);
        end
    end

    // store entries
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end

endmodule

// File: hdl/qpn_front.sv
// qpn_front: Hamilton product, magnitude scaling and sum of squares.
// Depends on qpn_pkg; feeds qpn_queue.
module qpn_front #(
    parameter int CW = qpn_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [8*CW-1:0]             i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [qpn_pkg::QENTRY_W-1:0] o_entry
);
    localparam int PW   = 2 * CW;
    localparam int TS   = (2 * CW > 60) ? (2 * CW - 60) : 0;
    localparam int SUMW = PW + 2;
    localparam int AW   = PW + 1;
    localparam int LW   = $clog2(AW + 1);
    localparam int AB   = qpn_pkg::A_BITS;
    localparam int QW   = qpn_pkg::ASQ_W;
    localparam int SW   = qpn_pkg::SUM_W;
    localparam int NST  = 6;
    localparam int X = 0, Y = 1, Z = 2, W = 3;

    logic             adv;
    logic [NST-1:0]   r_vld;

    logic signed [CW-1:0]   w_l [4];
    logic signed [CW-1:0]   w_r [4];
    logic signed [PW-1:0]   r_pr [16];
    logic signed [SUMW-1:0] n_p [4];
    logic signed [SUMW-1:0] r_p [4];
    logic [AW-1:0]          r_a [4];
    logic [3:0]             r_sg3, r_sg4, r_sg5, r_sg6;
    logic                   r_z3, r_z4, r_z5, r_z6;
    logic [AW-1:0]          w_or;
    logic [LW-1:0]          w_bl;
    logic [LW-1:0]          w_k;
    logic [AB-1:0]          r_a4 [4];
    logic [QW-1:0]          r_asq5 [4];
    logic [QW-1:0]          r_asq6 [4];
    logic [SW-1:0]          r_s6;

    assign adv     = !r_vld[NST-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NST-1];
    assign o_entry = {r_z6, r_sg6, r_s6, r_asq6[3], r_asq6[2], r_asq6[1], r_asq6[0]};

    // truncate a product magnitude toward zero
    function automatic logic signed [SUMW-1:0] f_term(input logic signed [PW-1:0] v);
        logic [PW-1:0] mag;
        mag = v[PW-1] ? (PW'(0) - PW'(v)) : PW'(v);
        mag = mag >> TS;
        return v[PW-1] ? (SUMW'(0) - SUMW'(mag)) : SUMW'(mag);
    endfunction

    // unpack components
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_l[i] = i_data[i*CW +: CW];
            w_r[i] = i_data[(i+4)*CW +: CW];
        end
    end

    // form component sums
    always_comb begin
        n_p[0] = f_term(r_pr[W*4+X]) + f_term(r_pr[X*4+W])
               + f_term(r_pr[Y*4+Z]) - f_term(r_pr[Z*4+Y]);
        n_p[1] = f_term(r_pr[W*4+Y]) + f_term(r_pr[Y*4+W])
               + f_term(r_pr[Z*4+X]) - f_term(r_pr[X*4+Z]);
        n_p[2] = f_term(r_pr[W*4+Z]) + f_term(r_pr[Z*4+W])
               + f_term(r_pr[X*4+Y]) - f_term(r_pr[Y*4+X]);
        n_p[3] = f_term(r_pr[W*4+W]) - f_term(r_pr[X*4+X])
               - f_term(r_pr[Y*4+Y]) - f_term(r_pr[Z*4+Z]);
    end

    // find the scaling shift from the widest magnitude
    always_comb begin
        w_or = r_a[0] | r_a[1] | r_a[2] | r_a[3];
        w_bl = '0;
        for (int i = 0; i < AW; i++) begin
            if (w_or[i]) w_bl = LW'(i + 1);
        end
        w_k = (w_bl > LW'(AB)) ? (w_bl - LW'(AB)) : '0;
    end

    // hold valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // advance the payload stages
    always_ff @(posedge i_clk) begin
        logic [AW+AB-1:0] sh;
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_pr[i*4+j] <= PW'(w_l[i]) * PW'(w_r[j]);
                end
            end
            for (int i = 0; i < 4; i++) begin
                r_p[i]   <= n_p[i];
                r_a[i]   <= r_p[i][SUMW-1] ? AW'(SUMW'(0) - r_p[i]) : AW'(r_p[i]);
                r_sg3[i] <= r_p[i][SUMW-1];
                sh        = {AB'(0), r_a[i]} >> w_k;
                r_a4[i]  <= sh[AB-1:0];
                r_asq5[i] <= QW'(r_a4[i]) * QW'(r_a4[i]);
                r_asq6[i] <= r_asq5[i];
            end
            r_z3  <= (r_p[0] == '0) && (r_p[1] == '0) && (r_p[2] == '0) && (r_p[3] == '0);
            r_z4  <= r_z3;
            r_z5  <= r_z4;
            r_z6  <= r_z5;
            r_sg4 <= r_sg3;
            r_sg5 <= r_sg4;
            r_sg6 <= r_sg5;
            r_s6  <= SW'(r_asq5[0]) + SW'(r_asq5[1]) + SW'(r_asq5[2]) + SW'(r_asq5[3]);
        end
    end

endmodule

// File: hdl/qpn_back.sv
// qpn_back: bit-per-stage root recurrence, rounding, saturation, output register.
// Depends on qpn_pkg; fed by qpn_queue.
module qpn_back #(
    parameter int CW = qpn_pkg::COMPONENT_WIDTH_DEF,
    parameter int FB = qpn_pkg::FRACTION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_pop,
    input  logic [qpn_pkg::QENTRY_W-1:0] i_entry,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [4*CW-1:0]              o_data,
    output logic                         o_zero
);
    localparam int QW = qpn_pkg::ASQ_W;
    localparam int SW = qpn_pkg::SUM_W;
    localparam int NB = FB + 2;
    localparam int WR = SW + 2 * NB + 2;
    localparam int VW = CW + 2;

    logic adv;
    logic [NB:0]   r_vs;
    logic [WR-1:0] r_rem  [NB+1][4];
    logic [WR-1:0] r_prod [NB+1][4];
    logic [NB-1:0] r_root [NB+1][4];
    logic [SW-1:0] r_sv   [NB+1];
    logic [3:0]    r_sg   [NB+1];
    logic          r_zf   [NB+1];
    logic [WR-1:0] n_rem  [NB+1][4];
    logic [WR-1:0] n_prod [NB+1][4];
    logic [NB-1:0] n_root [NB+1][4];
    logic [CW-1:0] n_out  [4];
    logic [4*CW-1:0] r_data;
    logic          r_zero;
    logic          r_ov;

    assign adv     = !r_ov || i_ready;
    assign o_pop   = adv;
    assign o_valid = r_ov;
    assign o_data  = r_data;
    assign o_zero  = r_zero;

    // one root bit per stage: try n + 2^j against the residual
    always_comb begin
        logic [WR-1:0] d;
        for (int s = 0; s <= NB; s++) begin
            for (int l = 0; l < 4; l++) begin
                n_rem[s][l]  = r_rem[s][l];
                n_prod[s][l] = r_prod[s][l];
                n_root[s][l] = r_root[s][l];
            end
        end
        for (int s = 1; s <= NB; s++) begin
            for (int l = 0; l < 4; l++) begin
                d = (r_prod[s-1][l] << (NB - s + 1)) + (WR'(r_sv[s-1]) << (2 * (NB - s)));
                n_rem[s][l]  = r_rem[s-1][l];
                n_prod[s][l] = r_prod[s-1][l];
                n_root[s][l] = r_root[s-1][l];
                if (d <= r_rem[s-1][l]) begin
                    n_rem[s][l]  = r_rem[s-1][l] - d;
                    n_prod[s][l] = r_prod[s-1][l] + (WR'(r_sv[s-1]) << (NB - s));
                    n_root[s][l] = r_root[s-1][l] | (NB'(1) << (NB - s));
                end
            end
        end
    end

    // round half up from the doubled root, apply sign, saturate
    always_comb begin
        logic [VW-1:0] m;
        logic [VW-1:0] maxv;
        maxv = (VW'(1) << (CW - 1)) - VW'(1);
        for (int l = 0; l < 4; l++) begin
            m = (VW'(r_root[NB][l]) + VW'(1)) >> 1;
            if (r_zf[NB]) begin
                n_out[l] = '0;
            end else if (!r_sg[NB][l]) begin
                n_out[l] = (m > maxv) ? CW'(maxv) : CW'(m);
            end else begin
                n_out[l] = (m > maxv + VW'(1)) ? CW'(VW'(0) - maxv - VW'(1))
                                               : CW'(VW'(0) - m);
            end
        end
    end

    // hold valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= '0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_vs <= {r_vs[NB-1:0], i_valid};
            r_ov <= r_vs[NB];
        end
    end

    // advance the payload stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 4; l++) begin
                r_rem[0][l]  <= WR'(i_entry[l*QW +: QW]) << (2 * FB + 2);
                r_prod[0][l] <= '0;
                r_root[0][l] <= '0;
            end
            r_sv[0] <= i_entry[4*QW +: SW];
            r_sg[0] <= i_entry[4*QW+SW +: 4];
            r_zf[0] <= i_entry[4*QW+SW+4];
            for (int s = 1; s <= NB; s++) begin
                for (int l = 0; l < 4; l++) begin
                    r_rem[s][l]  <= n_rem[s][l];
                    r_prod[s][l] <= n_prod[s][l];
                    r_root[s][l] <= n_root[s][l];
                end
                r_sv[s] <= r_sv[s-1];
                r_sg[s] <= r_sg[s-1];
                r_zf[s] <= r_zf[s-1];
            end
            r_data <= {n_out[3], n_out[2], n_out[1], n_out[0]};
            r_zero <= r_zf[NB];
        end
    end

endmodule
